// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and codes of the sorted priority queue
// no dependencies; used by the channel interfaces, spq_store and the top level
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int ELEM_W   = 32;
  localparam int PRIO_W   = 16;
  localparam int TOTAL_W  = $clog2(CAPACITY + 1);
  localparam int STATUS_W = 2;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

// ===== rtl/spq_if.sv =====
// spq_req_if and spq_rsp_if: valid/ready channels of the sorted priority queue
// depends on spq_pkg for field widths
`timescale 1ns / 1ps

interface spq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [spq_pkg::ELEM_W-1:0]  elem_value;
  logic [spq_pkg::PRIO_W-1:0]  priority_value;

  modport source (output valid, func, elem_value, priority_value, input ready);
  modport sink   (input valid, func, elem_value, priority_value, output ready);
endinterface

interface spq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::ELEM_W-1:0]    head_elem;
  logic [spq_pkg::PRIO_W-1:0]    head_priority;
  logic [spq_pkg::TOTAL_W-1:0]   entry_total;
  logic                          is_empty;
  logic [spq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, head_elem, head_priority, entry_total, is_empty, status,
                  input ready);
  modport sink   (input valid, head_elem, head_priority, entry_total, is_empty, status,
                  output ready);
endinterface

// ===== rtl/spq_store.sv =====
// spq_store: entry memory of the queue, one write and one registered read per cycle
// depends on spq_pkg for the entry type
`timescale 1ns / 1ps

module spq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  spq_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output spq_pkg::entry_t rd_data
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// sorted_priority_queue: bounded min-first priority queue, stable within one priority
// depends on spq_pkg, spq_req_if, spq_rsp_if and spq_store
//
//   channel | dir | fields
//   req     | in  | func, elem_value, priority_value
//   rsp     | out | head_elem, head_priority, entry_total, is_empty, status
//
// entries sit in a circular memory from a head pointer; a dequeue moves the pointer and
// reads the new head, skipping the read when it empties the queue or finds it empty.
// an enqueue walks back from the tail through spq_store, reading one entry in S_RD and
// in S_CMP either moving it back one slot or writing the new item behind it; it writes
// straight to the head slot when it becomes the head, and drops the item when full.
// req.ready is high only in the idle state; a result waiting in the rsp register stalls
// the next one only at its final step. synchronous reset empties the queue at once.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic         clk,
  input  logic         rst,
  spq_req_if.sink      req,
  spq_rsp_if.source    rsp
);
  import spq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S   = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_IX = AW'(CAPACITY - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_HRD  = 6'b001000,
    S_HLD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   hptr;
  logic [CW-1:0]   k;
  entry_t          new_ent;
  entry_t          hd;
  status_t         st;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;

  logic [CW-1:0]   off;
  logic [SW-1:0]   sum;
  logic [AW-1:0]   phys;
  logic [AW-1:0]   hptr_inc;
  logic            accept;
  logic            rsp_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_load  = (state == S_FIN) && (!rsp.valid || rsp.ready);
  assign hptr_inc  = (hptr == LAST_IX) ? '0 : hptr + AW'(1);

  // shared address unit: logical slot to memory index
  always_comb begin
    off  = (state == S_RD) ? k - CW'(1) : k;
    sum  = SW'(hptr) + SW'(off);
    phys = (sum >= CAP_S) ? AW'(sum - CAP_S) : AW'(sum);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys;
    wr_data = new_ent;
    rd_addr = (state == S_HRD) ? hptr : phys;
    unique case (state)
      S_RD: begin
        if (k == '0) begin
          wr_en   = 1'b1;
          wr_addr = hptr;
        end
      end
      S_CMP: begin
        wr_en = 1'b1;
        if (rd_data.prio > new_ent.prio) begin
          wr_data = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  spq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      hptr  <= '0;
      k     <= '0;
      st    <= ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            new_ent <= '{elem: req.elem_value, prio: req.priority_value};
            if (func_t'(req.func) == FUNC_DEQ) begin
              if (cnt == '0) begin
                st    <= ST_EMPTY;
                state <= S_FIN;
              end else begin
                st    <= ST_DONE;
                cnt   <= cnt - CW'(1);
                hptr  <= hptr_inc;
                state <= (cnt == CW'(1)) ? S_FIN : S_HRD;
              end
            end else begin
              if (cnt == CAP_C) begin
                st    <= ST_FULL;
                state <= S_FIN;
              end else begin
                st    <= ST_DONE;
                k     <= cnt;
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          if (k == '0) begin
            hd    <= new_ent;
            cnt   <= cnt + CW'(1);
            state <= S_FIN;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data.prio > new_ent.prio) begin
            k     <= k - CW'(1);
            state <= S_RD;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_FIN;
          end
        end
        S_HRD: begin
          state <= S_HLD;
        end
        S_HLD: begin
          hd    <= rd_data;
          state <= S_FIN;
        end
        S_FIN: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.head_elem     <= (cnt == '0) ? '0 : hd.elem;
      rsp.head_priority <= (cnt == '0) ? '0 : hd.prio;
      rsp.entry_total   <= TOTAL_W'(cnt);
      rsp.is_empty      <= (cnt == '0);
      rsp.status        <= st;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_C)
    else $error("entry count above capacity");

  a_cmp_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> k != '0)
    else $error("compare step at head slot");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    accept && func_t'(req.func) == FUNC_DEQ && cnt == '0 |=> state == S_FIN && st == ST_EMPTY)
    else $error("dequeue on empty queue not flagged");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    rsp_load && st == ST_FULL |=> rsp.entry_total == TOTAL_W'(CAPACITY))
    else $error("dropped enqueue with queue not full");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !accept |=> $stable(cnt))
    else $error("entry count moved without an item");

endmodule
